@@ hdl/mls_pkg.sv @@
`default_nettype none

package mls_pkg;

    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_END   = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_LEN,
        ST_POP_RUN
    } state_t;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

`default_nettype wire

@@ hdl/mls_ram.sv @@
`default_nettype none

module mls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/message_lifo_stack.sv @@
`default_nettype none

// channel   direction  handshake              beat
// command   in         start high, busy low   cmd, push_byte
// result    out        strobe, one cycle      status, out_byte, byte_valid, last
//
// push, end push, clear and a pop of an empty stack leave busy low; the result of
// an end push, clear or empty pop appears on the cycle after the command is taken.
// a pop of a non-empty stack holds busy through the length memory read, then sends
// one byte per cycle from the single store read port.
// rst_n clears the stack depth, fill count, too-long flag and sequencer; the
// memories are not cleared. the receiver cannot stall, so results never wait.

module message_lifo_stack #(
    parameter int STACK_ENTRIES     = 8,
    parameter int MAX_MESSAGE_BYTES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mls_pkg::CMD_W-1:0]     cmd,
    input  wire logic [mls_pkg::BYTE_W-1:0]    push_byte,
    output logic                               strobe,
    output logic                               status,
    output logic      [mls_pkg::BYTE_W-1:0]    out_byte,
    output logic                               byte_valid,
    output logic                               last
);

    localparam int SLOT_W   = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int DEPTH_W  = $clog2(STACK_ENTRIES + 1);
    localparam int POS_W    = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int FILL_W   = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int ADDR_W   = SLOT_W + POS_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int LEN_DEPTH   = 1 << SLOT_W;

    mls_pkg::state_t state_reg, state_next;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               too_long_reg, too_long_next;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  len_reg, len_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;

    logic                       strobe_reg, strobe_next;
    logic                       status_reg, status_next;
    logic [mls_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       byte_valid_reg, byte_valid_next;
    logic                       last_reg, last_next;

    logic                       accept;
    mls_pkg::cmd_t              cmd_in;
    logic [DEPTH_W-1:0]         depth_dec;

    logic                       store_we;
    logic [ADDR_W-1:0]          store_waddr;
    logic [ADDR_W-1:0]          store_raddr;
    logic [mls_pkg::BYTE_W-1:0] store_rdata;

    logic                       len_we;
    logic [SLOT_W-1:0]          len_waddr;
    logic [SLOT_W-1:0]          len_raddr;
    logic [FILL_W-1:0]          len_rdata;

    assign busy   = (state_reg != mls_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign cmd_in = mls_pkg::cmd_t'(cmd);

    assign depth_dec = DEPTH_W'(depth_reg - 1'b1);

    // length of the top message, read every cycle so it is ready after a pop
    assign len_raddr = depth_dec[SLOT_W-1:0];
    assign len_waddr = depth_reg[SLOT_W-1:0];

    mls_ram #(
        .WIDTH (mls_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (push_byte),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    mls_ram #(
        .WIDTH (FILL_W),
        .DEPTH (LEN_DEPTH)
    ) u_lengths (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (fill_reg),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        fill_next       = fill_reg;
        too_long_next   = too_long_reg;
        slot_next       = slot_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        strobe_next     = 1'b0;
        status_next     = mls_pkg::STATUS_OK;
        out_byte_next   = '0;
        byte_valid_next = 1'b0;
        last_next       = 1'b0;
        store_we        = 1'b0;
        store_waddr     = {depth_reg[SLOT_W-1:0], fill_reg[POS_W-1:0]};
        store_raddr     = {slot_reg, idx_reg[POS_W-1:0]};
        len_we          = 1'b0;

        unique case (state_reg)
            mls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        mls_pkg::CMD_PUSH:
                        begin
                            if (fill_reg >= FILL_W'(MAX_MESSAGE_BYTES))
                            begin
                                too_long_next = 1'b1;
                            end
                            else
                            begin
                                // byte is counted but not stored when the stack is full
                                store_we  = (depth_reg < DEPTH_W'(STACK_ENTRIES));
                                fill_next = FILL_W'(fill_reg + 1'b1);
                            end
                        end
                        mls_pkg::CMD_END:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (depth_reg < DEPTH_W'(STACK_ENTRIES) && !too_long_reg)
                            begin
                                len_we     = 1'b1;
                                depth_next = DEPTH_W'(depth_reg + 1'b1);
                            end
                            else
                            begin
                                status_next = mls_pkg::STATUS_REJECT;
                            end
                            fill_next     = '0;
                            too_long_next = 1'b0;
                        end
                        mls_pkg::CMD_POP:
                        begin
                            fill_next     = '0;
                            too_long_next = 1'b0;
                            if (depth_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = mls_pkg::STATUS_REJECT;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                depth_next = depth_dec;
                                slot_next  = depth_dec[SLOT_W-1:0];
                                state_next = mls_pkg::ST_POP_LEN;
                            end
                        end
                        mls_pkg::CMD_CLEAR:
                        begin
                            fill_next     = '0;
                            too_long_next = 1'b0;
                            depth_next    = '0;
                            strobe_next   = 1'b1;
                            last_next     = 1'b1;
                        end
                        default:
                        begin
                            state_next = mls_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mls_pkg::ST_POP_LEN:
            begin
                // first byte address goes out while the length is captured
                store_raddr = {slot_reg, POS_W'(0)};
                len_next    = len_rdata;
                idx_next    = FILL_W'(1);
                if (len_rdata == '0)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = mls_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mls_pkg::ST_POP_RUN;
                end
            end
            mls_pkg::ST_POP_RUN:
            begin
                strobe_next     = 1'b1;
                out_byte_next   = store_rdata;
                byte_valid_next = 1'b1;
                idx_next        = FILL_W'(idx_reg + 1'b1);
                if (idx_reg == len_reg)
                begin
                    last_next  = 1'b1;
                    state_next = mls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mls_pkg::ST_IDLE;
            depth_reg    <= '0;
            fill_reg     <= '0;
            too_long_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            fill_reg     <= fill_next;
            too_long_reg <= too_long_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        last_reg       <= last_next;
    end

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ sim/mls_checker.sv @@
`default_nettype none

module mls_checker
    import mls_pkg::*;
#(
    parameter int STACK_ENTRIES     = 8,
    parameter int MAX_MESSAGE_BYTES = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [BYTE_W-1:0]   push_byte,
    input  wire logic                strobe,
    input  wire logic                status,
    input  wire logic [BYTE_W-1:0]   out_byte,
    input  wire logic                byte_valid,
    input  wire logic                last,
    output int                       failures,
    output int                       outstanding
);

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } beat_t;

    // shadow copy of the stack contents
    logic [BYTE_W-1:0] shadow_store [STACK_ENTRIES][MAX_MESSAGE_BYTES];
    logic [5:0]        shadow_len   [STACK_ENTRIES];
    logic [3:0]        depth;
    logic [5:0]        fill;
    logic              too_long;

    beat_t awaited_beats[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        depth       = '0;
        fill        = '0;
        too_long    = 1'b0;
    end

    function automatic beat_t make_beat(logic st, logic [BYTE_W-1:0] d, logic v, logic l);
        beat_t b;
        b.status = st;
        b.data   = d;
        b.valid  = v;
        b.last   = l;
        return b;
    endfunction

    // updates the shadow stack for one command and queues the beats it yields
    task automatic stack_results_for(input cmd_t c, input logic [BYTE_W-1:0] b);
        logic [5:0] len;
        logic       rejected;
        case (c)
            CMD_PUSH:
            begin
                if (fill >= MAX_MESSAGE_BYTES)
                    too_long = 1'b1;
                else
                begin
                    // bytes pushed while full are counted but dropped
                    if (depth < STACK_ENTRIES)
                        shadow_store[depth][fill] = b;
                    fill = fill + 1'b1;
                end
            end
            CMD_END:
            begin
                rejected = (depth >= STACK_ENTRIES) || too_long;
                if (!rejected)
                begin
                    shadow_len[depth] = fill;
                    depth = depth + 1'b1;
                end
                fill     = '0;
                too_long = 1'b0;
                awaited_beats.push_back(make_beat(rejected ? STATUS_REJECT : STATUS_OK,
                                                  '0, 1'b0, 1'b1));
            end
            CMD_CLEAR:
            begin
                fill     = '0;
                too_long = 1'b0;
                depth    = '0;
                awaited_beats.push_back(make_beat(STATUS_OK, '0, 1'b0, 1'b1));
            end
            default:
            begin
                fill     = '0;
                too_long = 1'b0;
                if (depth == 0)
                    awaited_beats.push_back(make_beat(STATUS_REJECT, '0, 1'b0, 1'b1));
                else
                begin
                    depth = depth - 1'b1;
                    len   = shadow_len[depth];
                    if (len == 0)
                        awaited_beats.push_back(make_beat(STATUS_OK, '0, 1'b0, 1'b1));
                    else
                        for (int i = 0; i < len; i++)
                            awaited_beats.push_back(make_beat(STATUS_OK, shadow_store[depth][i],
                                                              1'b1, (i + 1 == len)));
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        beat_t seen;
        beat_t want;
        if (rst_n === 1'b1)
        begin
            if (strobe === 1'b1)
            begin
                seen = make_beat(status, out_byte, byte_valid, last);
                if (awaited_beats.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected beat status %0b data %02h valid %0b last %0b",
                             $time, seen.status, seen.data, seen.valid, seen.last);
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    if (seen !== want)
                    begin
                        failures++;
                        $display("%0t: beat mismatch, expected status %0b data %02h valid %0b last %0b, got status %0b data %02h valid %0b last %0b",
                                 $time, want.status, want.data, want.valid, want.last,
                                 seen.status, seen.data, seen.valid, seen.last);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                stack_results_for(cmd_t'(cmd), push_byte);
            outstanding = awaited_beats.size();
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
    import mls_pkg::*;

    localparam int MAX_BYTES   = 32;
    localparam int ITEM_TARGET = 100;
    localparam int DRAIN_WAIT  = 40;
    localparam int RUN_LIMIT   = 400000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    cmd_t              cmd       = CMD_PUSH;
    logic [BYTE_W-1:0] push_byte = '0;
    logic              busy;
    logic              strobe;
    logic              status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    int                failures;
    int                outstanding;

    int burst_left = 0;
    int issued     = 0;

    always #4 clk = ~clk;

    message_lifo_stack u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .push_byte  (push_byte),
        .strobe     (strobe),
        .status     (status),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

    mls_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .push_byte   (push_byte),
        .strobe      (strobe),
        .status      (status),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // one command, returns once it has been taken
    task automatic issue(input cmd_t c, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        issued++;
        start     <= 1'b1;
        cmd       <= c;
        push_byte <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_message(input int len, input cmd_t ending);
        for (int i = 0; i < len; i++)
            issue(CMD_PUSH, BYTE_W'($urandom_range(0, 255)));
        issue(ending, BYTE_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int   len;
        int   pick;
        cmd_t ending;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack: pop is refused, clear still answers
        issue(CMD_POP, 8'h00);
        issue(CMD_CLEAR, 8'hFF);
        // zero-length message round trip
        issue(CMD_END, 8'h00);
        issue(CMD_POP, 8'h00);
        // byte extremes
        issue(CMD_PUSH, 8'h00);
        issue(CMD_PUSH, 8'hFF);
        issue(CMD_END, 8'h00);
        issue(CMD_POP, 8'h00);
        // partial message dropped by pop, then by clear
        issue(CMD_PUSH, 8'h5A);
        issue(CMD_POP, 8'h00);
        issue(CMD_PUSH, 8'hA5);
        issue(CMD_CLEAR, 8'h00);
        // fill every slot, then commits are refused
        repeat (8) issue(CMD_END, 8'h00);
        issue(CMD_END, 8'h00);
        issue(CMD_PUSH, 8'h3C);
        issue(CMD_END, 8'h00);
        issue(CMD_POP, 8'h00);
        issue(CMD_CLEAR, 8'h00);

        while (issued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                case ($urandom_range(0, 15))
                    0:       len = MAX_BYTES;
                    1:       len = MAX_BYTES + $urandom_range(1, 3);
                    2:       len = MAX_BYTES - 1;
                    default: len = $urandom_range(0, 6);
                endcase
                case ($urandom_range(0, 9))
                    0:       ending = CMD_POP;
                    1:       ending = CMD_CLEAR;
                    default: ending = CMD_END;
                endcase
                send_message(len, ending);
            end
            else if (pick < 82)
                issue(CMD_POP, BYTE_W'($urandom_range(0, 255)));
            else if (pick < 87)
                issue(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)));
            else
                issue(cmd_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
        end
        start <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        // let any stray beat show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("message_lifo_stack regression: pass");
        else
            $display("message_lifo_stack regression: fail");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("message_lifo_stack regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/mls_pkg.sv
hdl/mls_ram.sv
hdl/message_lifo_stack.sv
sim/mls_checker.sv
sim/tb_top.sv
